@@ sv/string_bucket_hash_assert.svh @@
// Assertion macros used by the string bucket hash datapath.
`ifndef STRING_BUCKET_HASH_ASSERT_SVH
`define STRING_BUCKET_HASH_ASSERT_SVH

// Checked on every clock edge outside reset.
`define SBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SBH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/sbh_pkg.sv @@
// Types and constants shared by the string bucket hash modules.
`timescale 1ns / 1ps
package sbh_pkg;

  localparam int BYTE_W    = 8;
  localparam int ACC_W     = 32;
  localparam int COUNT_W   = 16;
  localparam int DIV_STEPS = ACC_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [ACC_W-1:0]   HASH_MUL           = 32'd149711;
  localparam int                 HASH_SHIFT         = 7;
  localparam logic [COUNT_W-1:0] BUCKET_COUNT_RESET = 16'd5;
  localparam logic [STEP_W-1:0]  LAST_STEP          = STEP_W'(DIV_STEPS - 1);

  // Register index of bucket_count, taken from paddr[2].
  localparam logic REG_BUCKET_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic acc_update;
    logic mul_load;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic byte_zero;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

@@ sv/string_bucket_hash.sv @@
// Top level of the string bucket hash: configuration port, controller, datapath.
//
//   channel   direction  handshake            payload
//   input     in         in_valid/in_ready    key_byte[7:0]
//   result    out        out_valid/out_ready  bucket_index[15:0]
//   config    in         psel/penable/pready  bucket_count at paddr 0
//
// A nonzero key byte is folded into the running hash. A zero byte multiplies the
// hash, loads the divider, runs the one-bit-per-cycle restoring remainder and
// then registers the result. Reset
// clears the running hash, the state machine and the result flag, and sets
// bucket_count to 5. A result held by a stalled consumer does not block nonzero
// bytes; the next result waits in its final state until the output register frees.
`timescale 1ns / 1ps
module string_bucket_hash (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sbh_pkg::BYTE_W-1:0]   key_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbh_pkg::COUNT_W-1:0]  bucket_index,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbh_pkg::ADDR_W-1:0]   paddr,
  input  logic [sbh_pkg::DATA_W-1:0]   pwdata,
  output logic [sbh_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import sbh_pkg::*;

  logic [COUNT_W-1:0] bucket_count;
  cmd_t               cmd;
  status_t            status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BUCKET_COUNT) begin
      bucket_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_BUCKET_COUNT) begin
      prdata = {{(DATA_W-COUNT_W){1'b0}}, bucket_count};
    end else begin
      prdata = '0;
    end
  end

  sbh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sbh_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .key_byte     (key_byte),
    .bucket_count (bucket_count),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bucket_index (bucket_index)
  );

endmodule

@@ sv/sbh_ctrl.sv @@
// Controller state machine for the string bucket hash.
`timescale 1ns / 1ps
module sbh_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sbh_pkg::status_t status,
  output sbh_pkg::cmd_t    cmd
);
  import sbh_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && status.byte_zero) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.acc_update = in_valid && !status.byte_zero;
        cmd.mul_load   = in_valid && status.byte_zero;
      end
      ST_LOAD: cmd.div_start = 1'b1;
      ST_DIV:  cmd.div_step  = 1'b1;
      ST_DONE: cmd.out_load  = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

@@ sv/sbh_datapath.sv @@
// Datapath: accumulator, multiplier, serial divider and output register.
`timescale 1ns / 1ps
module sbh_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [sbh_pkg::BYTE_W-1:0]   key_byte,
  input  logic [sbh_pkg::COUNT_W-1:0]  bucket_count,
  input  sbh_pkg::cmd_t                cmd,
  output sbh_pkg::status_t             status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbh_pkg::COUNT_W-1:0]  bucket_index
);
  import sbh_pkg::*;

  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   prod;
  logic [ACC_W-1:0]   dvd;
  logic [COUNT_W-1:0] rem;
  logic [STEP_W-1:0]  step;
  logic               neg;

  logic [COUNT_W:0]   rem_shift;
  logic [COUNT_W:0]   rem_diff;
  logic [COUNT_W-1:0] bucket_next;

  assign rem_shift = {rem, dvd[ACC_W-1]};
  assign rem_diff  = rem_shift - {1'b0, bucket_count};

  always_comb begin
    if (bucket_count == '0) begin
      bucket_next = '0;
    end else if (neg && rem != '0) begin
      bucket_next = bucket_count - rem;
    end else begin
      bucket_next = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.mul_load) begin
      acc <= '0;
    end else if (cmd.acc_update) begin
      acc <= acc + (acc << HASH_SHIFT) + {{(ACC_W-BYTE_W){1'b0}}, key_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= ACC_W'(acc * HASH_MUL);
    end
    if (cmd.div_start) begin
      neg  <= prod[ACC_W-1];
      dvd  <= prod[ACC_W-1] ? (~prod + 1'b1) : prod;
      rem  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      dvd  <= dvd << 1;
      rem  <= rem_diff[COUNT_W] ? rem_shift[COUNT_W-1:0] : rem_diff[COUNT_W-1:0];
      step <= step + 1'b1;
    end
    if (cmd.out_load) begin
      bucket_index <= bucket_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.byte_zero = (key_byte == '0);
  assign status.div_last  = (step == LAST_STEP);
  assign status.out_busy  = out_valid && !out_ready;

`include "string_bucket_hash_assert.svh"

  `SBH_ASSERT(a_div_start_clears, cmd.div_start |=> (rem == '0 && step == '0), "divider not cleared")
  `SBH_ASSERT(a_rem_bound, (cmd.div_step && bucket_count != '0) |=> rem < bucket_count, "remainder out of range")
  `SBH_ASSERT(a_load_sets_valid, cmd.out_load |=> out_valid, "result not presented")
  `SBH_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result pending after reset")

endmodule
